>>> src/utf8_byte_stream_validator_assert.svh
// Assertion macros shared by the validator modules.
// Each expects signals named clk and rst_n in the enclosing module.
`ifndef UTF8_BYTE_STREAM_VALIDATOR_ASSERT_SVH
`define UTF8_BYTE_STREAM_VALIDATOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define UTF8V_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8v assertion failed");
`define UTF8V_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8v assertion failed");
`else
`define UTF8V_ASSERT_IMP(label, ante, cons)
`define UTF8V_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> src/utf8v_pkg.sv
`default_nettype none

package utf8v_pkg;

    localparam logic [7:0] ASCII_MAX = 8'h7F;
    localparam logic [7:0] CONT_MIN  = 8'h80;
    localparam logic [7:0] CONT_MAX  = 8'hBF;
    localparam logic [7:0] LEAD2_MIN = 8'hC0;
    localparam logic [7:0] LEAD2_MAX = 8'hDF;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] LEAD4_MAX = 8'hF7;

    typedef logic [1:0] pend_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       first_of_file;
        logic       last_of_file;
    } in_item_t;

    typedef struct packed {
        logic       valid_so_far;
        logic       verdict_final;
        logic [7:0] offending_lead;
    } out_item_t;

endpackage

`default_nettype wire

>>> src/utf8v_in_stage.sv
`default_nettype none

module utf8v_in_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire utf8v_pkg::in_item_t item,
    input  wire logic               advance,
    output logic                    stage_valid,
    output utf8v_pkg::in_item_t     stage_item
);
    import utf8v_pkg::*;

    logic     stage_valid_reg;
    logic     stage_valid_next;
    in_item_t stage_item_reg;
    logic     load;

    // hold the item while the check stage cannot take it
    assign item_stall       = stage_valid_reg && !advance;
    assign load             = item_valid && !item_stall;
    assign stage_valid_next = load || (stage_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_item_reg <= item;
        end
    end

    assign stage_valid = stage_valid_reg;
    assign stage_item  = stage_item_reg;

endmodule

`default_nettype wire

>>> src/utf8v_check.sv
`default_nettype none

`include "utf8_byte_stream_validator_assert.svh"

module utf8v_check (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire utf8v_pkg::in_item_t stage_item,
    output utf8v_pkg::out_item_t     result_next
);
    import utf8v_pkg::*;

    pend_t      pend_reg, pend_next;
    logic [7:0] lead_reg, lead_next;
    logic       err_reg, err_next;
    logic [7:0] bad_reg, bad_next;

    pend_t      pend_cur;
    logic [7:0] lead_cur;
    logic       err_cur;
    logic [7:0] bad_cur;
    logic [7:0] b;
    logic       is_ascii, is_cont, is_lead2, is_lead3, is_lead4;
    logic       broken, fresh_err, tail_err, new_err;
    pend_t      pend_seq;
    logic [7:0] err_lead;

    always_comb
    begin
        b        = stage_item.byte_value;
        // start flag clears the state before this byte
        pend_cur = stage_item.first_of_file ? '0    : pend_reg;
        lead_cur = stage_item.first_of_file ? 8'h00 : lead_reg;
        err_cur  = stage_item.first_of_file ? 1'b0  : err_reg;
        bad_cur  = stage_item.first_of_file ? 8'h00 : bad_reg;

        is_ascii = (b <= ASCII_MAX);
        is_cont  = (b >= CONT_MIN)  && (b <= CONT_MAX);
        is_lead2 = (b >= LEAD2_MIN) && (b <= LEAD2_MAX);
        is_lead3 = (b >= LEAD3_MIN) && (b <= LEAD3_MAX);
        is_lead4 = (b >= LEAD4_MIN) && (b <= LEAD4_MAX);

        broken    = (pend_cur != '0) && !is_cont;
        fresh_err = 1'b0;
        lead_next = lead_cur;

        if ((pend_cur != '0) && is_cont)
        begin
            pend_seq = pend_cur - 2'd1;
        end
        else
        begin
            // drop any open sequence and check the byte as fresh
            pend_seq = '0;
            if (is_lead2)
            begin
                pend_seq  = 2'd1;
                lead_next = b;
            end
            else if (is_lead3)
            begin
                pend_seq  = 2'd2;
                lead_next = b;
            end
            else if (is_lead4)
            begin
                pend_seq  = 2'd3;
                lead_next = b;
            end
            else if (!is_ascii)
            begin
                fresh_err = 1'b1;
            end
        end

        tail_err  = stage_item.last_of_file && (pend_seq != '0);
        pend_next = stage_item.last_of_file ? '0 : pend_seq;
        new_err   = broken || fresh_err || tail_err;

        // earliest error in the byte wins
        if (broken)
        begin
            err_lead = lead_cur;
        end
        else if (fresh_err)
        begin
            err_lead = b;
        end
        else
        begin
            err_lead = lead_next;
        end

        err_next = err_cur || new_err;
        bad_next = (!err_cur && new_err) ? err_lead : bad_cur;

        result_next.valid_so_far   = !err_next;
        result_next.verdict_final  = stage_item.last_of_file;
        result_next.offending_lead = bad_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            lead_reg <= 8'h00;
            err_reg  <= 1'b0;
            bad_reg  <= 8'h00;
        end
        else if (advance)
        begin
            pend_reg <= pend_next;
            lead_reg <= lead_next;
            err_reg  <= err_next;
            bad_reg  <= bad_next;
        end
    end

    // a recorded lead is never an ASCII byte
    `UTF8V_ASSERT_IMP(a_bad_lead_high, err_reg, bad_reg[7])
    // an open sequence always belongs to a multi-byte lead
    `UTF8V_ASSERT_IMP(a_open_lead, pend_reg != '0, lead_reg[7:6] == 2'b11)

endmodule

`default_nettype wire

>>> src/utf8_byte_stream_validator.sv
// Lenient UTF-8 stream checker. Bytes of a file arrive one item at a time;
// one result item comes back for every byte, carrying the running verdict
// and the lead byte of the first bad sequence. The block takes one byte per
// clock while it is not stalled. An accepted byte sits in the input register,
// passes the single check stage that updates the sequence state, and lands
// in the result register once that register is free or its result is taken,
// where its result is offered. A stalled result holds the pipe only once
// both registers are full.
`default_nettype none

`include "utf8_byte_stream_validator_assert.svh"

module utf8_byte_stream_validator (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire utf8v_pkg::in_item_t  item,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output utf8v_pkg::out_item_t      result
);
    import utf8v_pkg::*;

    logic      stage_valid;
    in_item_t  stage_item;
    logic      advance;
    out_item_t result_next;
    logic      result_valid_reg;
    logic      result_valid_next;
    out_item_t result_reg;

    // move the staged item into the result register when it is free
    assign advance           = stage_valid && (!result_valid_reg || !result_stall);
    assign result_valid_next = advance || (result_valid_reg && result_stall);

    utf8v_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    utf8v_check u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .stage_item  (stage_item),
        .result_next (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // a clean verdict and a zero lead go together
    `UTF8V_ASSERT_IMP(a_verdict_lead, result_valid_reg,
        result_reg.valid_so_far == (result_reg.offending_lead == 8'h00))
    // a staged item that cannot move stays staged
    `UTF8V_ASSERT_NEXT(a_stage_kept, stage_valid && !advance, stage_valid)

endmodule

`default_nettype wire

>>> verif/utf8_stream_checker.sv
`default_nettype none

module utf8_stream_checker (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    input  wire logic                 item_stall,
    input  wire utf8v_pkg::in_item_t  item,
    input  wire logic                 result_valid,
    input  wire logic                 result_stall,
    input  wire utf8v_pkg::out_item_t result,
    output int                        fail_count,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import utf8v_pkg::*;

    // shadow of the block's sequence state
    pend_t      seq_left;
    logic [7:0] seq_lead;
    logic       err_flag;
    logic [7:0] err_lead;

    out_item_t  verdict_q[$];

    function automatic void note_error(logic [7:0] lead);
        if (!err_flag) begin
            err_flag = 1'b1;
            err_lead = lead;
        end
    endfunction

    // classify a byte that does not continue an open sequence
    function automatic void start_seq(logic [7:0] b);
        if (b <= ASCII_MAX) begin
            seq_left = 2'd0;
        end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
            seq_left = 2'd1;
            seq_lead = b;
        end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
            seq_left = 2'd2;
            seq_lead = b;
        end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
            seq_left = 2'd3;
            seq_lead = b;
        end else begin
            seq_left = 2'd0;
            note_error(b);
        end
    endfunction

    function automatic out_item_t check_byte(in_item_t it);
        out_item_t r;
        if (it.first_of_file) begin
            seq_left = 2'd0;
            seq_lead = 8'h00;
            err_flag = 1'b0;
            err_lead = 8'h00;
        end
        if (seq_left != 2'd0) begin
            if (it.byte_value >= CONT_MIN && it.byte_value <= CONT_MAX) begin
                seq_left = seq_left - 2'd1;
            end else begin
                // drop the open sequence, then recheck the byte on its own
                note_error(seq_lead);
                seq_left = 2'd0;
                start_seq(it.byte_value);
            end
        end else begin
            start_seq(it.byte_value);
        end
        if (it.last_of_file) begin
            if (seq_left != 2'd0)
                note_error(seq_lead);
            seq_left = 2'd0;
        end
        r.valid_so_far   = !err_flag;
        r.verdict_final  = it.last_of_file;
        r.offending_lead = err_lead;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp;
        if (!rst_n) begin
            seq_left   = 2'd0;
            seq_lead   = 8'h00;
            err_flag   = 1'b0;
            err_lead   = 8'h00;
            fail_count = 0;
            verdict_q.delete();
            pending <= 0;
        end else begin
            // compare before pushing so a stray result cannot match a fresh item
            if (result_valid && !result_stall) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("result item with no byte outstanding");
                end else begin
                    exp = verdict_q.pop_front();
                    if (result.valid_so_far !== exp.valid_so_far)
                        report_mismatch($sformatf("valid_so_far %b, expected %b",
                            result.valid_so_far, exp.valid_so_far));
                    if (result.verdict_final !== exp.verdict_final)
                        report_mismatch($sformatf("verdict_final %b, expected %b",
                            result.verdict_final, exp.verdict_final));
                    if (result.offending_lead !== exp.offending_lead)
                        report_mismatch($sformatf("offending_lead %h, expected %h",
                            result.offending_lead, exp.offending_lead));
                end
            end
            if (item_valid && !item_stall)
                verdict_q.push_back(check_byte(item));
            pending <= verdict_q.size();
        end
    end

endmodule

`default_nettype wire

>>> verif/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import utf8v_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 3000;
    localparam int PHASE_ITEMS = 430;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_stall;
    in_item_t  item         = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;

    int fail_count;
    int pending;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int hold_req    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int sent        = 0;
    int quiet_count = 0;

    logic [7:0] file_bytes[$];

    utf8_byte_stream_validator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    utf8_stream_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always #6 clk = ~clk;

    // result side: random stall, or a long hold when one is requested
    always @(posedge clk)
    begin
        if (hold_req != hold_seen) begin
            hold_seen    <= hold_req;
            hold_left    <= HOLD_CYCLES;
            result_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end else begin
            result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet_count <= 0;
            else
                quiet_count <= quiet_count + 1;
            if (quiet_count >= QUIET_LIMIT) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic first, logic last);
        while ($urandom_range(99) < idle_pct) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item.byte_value    <= b;
        item.first_of_file <= first;
        item.last_of_file  <= last;
        item_valid         <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // mostly well-formed sequences, some cut short, some raw noise
    task automatic build_file();
        int         nseq;
        int         kind;
        int         ncont;
        logic [7:0] lead;
        file_bytes.delete();
        nseq = $urandom_range(1, 6);
        for (int k = 0; k < nseq; k++) begin
            kind  = $urandom_range(99);
            ncont = $urandom_range(kind < 80 ? 0 : 1, 3);
            case (ncont)
                1: lead = 8'($urandom_range(LEAD2_MIN, LEAD2_MAX));
                2: lead = 8'($urandom_range(LEAD3_MIN, LEAD3_MAX));
                3: lead = 8'($urandom_range(LEAD4_MIN, LEAD4_MAX));
                default: lead = 8'($urandom_range(0, ASCII_MAX));
            endcase
            if (kind >= 90) begin
                file_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                file_bytes.push_back(lead);
                // truncate broken sequences short of their full length
                if (kind >= 80)
                    ncont = $urandom_range(0, ncont - 1);
                repeat (ncont)
                    file_bytes.push_back(8'($urandom_range(CONT_MIN, CONT_MAX)));
            end
        end
    endtask

    task automatic send_file();
        logic first;
        logic last;
        for (int i = 0; i < file_bytes.size(); i++) begin
            first = (i == 0) ? ($urandom_range(19) != 0) : ($urandom_range(99) == 0);
            last  = (i == file_bytes.size() - 1) ? ($urandom_range(19) != 0)
                                                 : ($urandom_range(99) == 0);
            send_byte(file_bytes[i], first, last);
        end
    endtask

    initial
    begin
        int idle_tab[4];
        int stall_tab[4];
        idle_tab  = '{0, 55, 0, 10};
        stall_tab = '{0, 0, 55, 10};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // continuation of a run never started, then a clean file
        send_byte(8'h41, 1'b0, 1'b0);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'h7F, 1'b0, 1'b0);
        send_byte(8'hC0, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'hE0, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'hBF, 1'b0, 1'b0);
        send_byte(8'hF7, 1'b0, 1'b0);
        send_byte(8'hBF, 1'b0, 1'b0);
        send_byte(8'hBF, 1'b0, 1'b0);
        send_byte(8'hBF, 1'b0, 1'b1);
        // stray continuation as a one-byte file
        send_byte(8'h80, 1'b1, 1'b1);
        // bytes past the last one keep the sticky error
        send_byte(8'h41, 1'b0, 1'b0);
        // invalid lead bytes; only the first is recorded
        send_byte(8'hFF, 1'b1, 1'b0);
        send_byte(8'hF8, 1'b0, 1'b0);
        send_byte(8'h41, 1'b0, 1'b1);
        // broken sequence, then the breaking byte opens its own
        send_byte(8'hDF, 1'b1, 1'b0);
        send_byte(8'hC3, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b1);
        // tail cut short by the last byte
        send_byte(8'hF0, 1'b1, 1'b0);
        send_byte(8'h90, 1'b0, 1'b1);
        send_byte(8'hEF, 1'b1, 1'b1);
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            idle_pct  = idle_tab[p];
            stall_pct <= stall_tab[p];
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                build_file();
                send_file();
            end
            wait_drained();

            if (p == 0) begin
                // keep offering items while results are held back
                hold_req <= hold_req + 1;
                sent = 0;
                while (sent < 40) begin
                    build_file();
                    send_file();
                end
                wait_drained();
            end
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
+incdir+src
src/utf8v_pkg.sv
src/utf8v_in_stage.sv
src/utf8v_check.sv
src/utf8_byte_stream_validator.sv
verif/utf8_stream_checker.sv
verif/testbench.sv
